// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the one-wire bus master.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/owm_pkg.sv =====
// Package for the one-wire bus master: phase codes, command codes,
// register indexes and register reset values. No dependencies.
`timescale 1ns / 1ps

package owm_pkg;

  localparam int CFG_W      = 10;
  localparam int SHORT_W    = 4;
  localparam int BYTE_W     = 8;
  localparam int BIT_IDX_W  = 3;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_RST_LOW    = 7'b0000010,
    PH_PRES_WAIT  = 7'b0000100,
    PH_RST_REC    = 7'b0001000,
    PH_SLOT_START = 7'b0010000,
    PH_SLOT_BODY  = 7'b0100000,
    PH_SLOT_REC   = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW   = 3'd0,
    REG_PRES_WAIT   = 3'd1,
    REG_RESET_REC   = 3'd2,
    REG_SLOT        = 3'd3,
    REG_START_LOW   = 3'd4,
    REG_RECOVERY    = 3'd5
  } reg_idx_t;

  localparam logic [CFG_W-1:0]   RST_RESET_LOW = 10'd400;
  localparam logic [CFG_W-1:0]   RST_PRES_WAIT = 10'd30;
  localparam logic [CFG_W-1:0]   RST_RESET_REC = 10'd400;
  localparam logic [CFG_W-1:0]   RST_SLOT      = 10'd40;
  localparam logic [SHORT_W-1:0] RST_START_LOW = 4'd2;
  localparam logic [SHORT_W-1:0] RST_RECOVERY  = 4'd1;

endpackage

// ===== src/one_wire_bus_master.sv =====
// One-wire bus master: the result word of an accepted tick word is valid in the cycle after,
// throughput one tick word per cycle, sustained while the result side keeps taking.
// The per-tick step is one pass of logic from the held state and the input word
// into the state registers and the output register.
// Synchronous active-low reset: phase idle, counters and shift byte cleared,
// presence and last read byte zero, timing registers at their default values.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module one_wire_bus_master #(
  parameter int TICK_COUNTER_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input word: cmd [1:0], data [9:2], line_in [10], zero fill above.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [owm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Result word: drive_low [0], busy_res [1], done_res [2], presence [3],
  // read_byte [11:4], cmd_rejected [12], zero fill above.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [owm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [owm_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [owm_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic [owm_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import owm_pkg::*;

  localparam int CW = TICK_COUNTER_BITS;
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [CW-1:0] CNT_MAX = '1;

  // Limit seen by the tick counter: clamped to the counter top, zero acts as one.
  function automatic logic [LW-1:0] clamp_lim(input logic [CFG_W-1:0] v);
    logic [LW-1:0] ext;
    logic [LW-1:0] top;
    ext = LW'(v);
    top = LW'(CNT_MAX);
    if (ext > top) ext = top;
    if (ext == '0) ext = LW'(1);
    return ext;
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0]   reset_low_r, pres_wait_r, reset_rec_r, slot_r;
  logic [SHORT_W-1:0] start_low_r, recovery_r;

  // Bus state.
  phase_t              phase_r, phase_nxt;
  cmd_t                op_r, op_nxt;
  logic [CW-1:0]       tick_count_r, tick_count_nxt;
  logic [BIT_IDX_W-1:0] bit_index_r, bit_index_nxt;
  logic [BYTE_W-1:0]   shift_byte_r, shift_byte_nxt;
  logic                presence_r, presence_nxt;
  logic [BYTE_W-1:0]   last_read_r, last_read_nxt;

  // Output register.
  logic                out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                in_fire, cfg_wr;
  cmd_t                cmd;
  logic [BYTE_W-1:0]   data;
  logic                line_in;
  logic                started;
  phase_t              phase_cur;
  logic [CW-1:0]       tc_cur, tc_inc;
  logic [LW-1:0]       lim_sel;
  logic                reached;
  logic                drive, busy, done, rejected;

  assign cmd     = cmd_t'(in_tdata[1:0]);
  assign data    = in_tdata[9:2];
  assign line_in = in_tdata[10];

  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    case (reg_idx_t'(cfg_paddr[4:2]))
      REG_RESET_LOW: cfg_prdata = APB_DATA_W'(reset_low_r);
      REG_PRES_WAIT: cfg_prdata = APB_DATA_W'(pres_wait_r);
      REG_RESET_REC: cfg_prdata = APB_DATA_W'(reset_rec_r);
      REG_SLOT:      cfg_prdata = APB_DATA_W'(slot_r);
      REG_START_LOW: cfg_prdata = APB_DATA_W'(start_low_r);
      REG_RECOVERY:  cfg_prdata = APB_DATA_W'(recovery_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r <= RST_RESET_LOW;
      pres_wait_r <= RST_PRES_WAIT;
      reset_rec_r <= RST_RESET_REC;
      slot_r      <= RST_SLOT;
      start_low_r <= RST_START_LOW;
      recovery_r  <= RST_RECOVERY;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[4:2]))
        REG_RESET_LOW: reset_low_r <= cfg_pwdata[CFG_W-1:0];
        REG_PRES_WAIT: pres_wait_r <= cfg_pwdata[CFG_W-1:0];
        REG_RESET_REC: reset_rec_r <= cfg_pwdata[CFG_W-1:0];
        REG_SLOT:      slot_r      <= cfg_pwdata[CFG_W-1:0];
        REG_START_LOW: start_low_r <= cfg_pwdata[SHORT_W-1:0];
        REG_RECOVERY:  recovery_r  <= cfg_pwdata[SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  // A command seen while idle starts at once; the start tick is the first
  // tick of the new phase.
  assign started   = (phase_r == PH_IDLE) && (cmd != CMD_NONE);
  assign rejected  = (phase_r != PH_IDLE) && (cmd != CMD_NONE);
  assign phase_cur = started ? ((cmd == CMD_RESET) ? PH_RST_LOW : PH_SLOT_START) : phase_r;
  assign tc_cur    = started ? '0 : tick_count_r;
  assign tc_inc    = (tc_cur == CNT_MAX) ? tc_cur : tc_cur + 1'b1;
  assign busy      = (phase_cur != PH_IDLE);

  always_comb begin
    case (phase_cur)
      PH_RST_LOW:    lim_sel = clamp_lim(reset_low_r);
      PH_PRES_WAIT:  lim_sel = clamp_lim(pres_wait_r);
      PH_RST_REC:    lim_sel = clamp_lim(reset_rec_r);
      PH_SLOT_START: lim_sel = clamp_lim(CFG_W'(start_low_r));
      PH_SLOT_BODY:  lim_sel = clamp_lim(slot_r);
      PH_SLOT_REC:   lim_sel = clamp_lim(CFG_W'(recovery_r));
      default:       lim_sel = LW'(1);
    endcase
  end

  assign reached = (LW'(tc_inc) >= lim_sel);

  always_comb begin
    op_nxt         = started ? cmd : op_r;
    bit_index_nxt  = started ? '0 : bit_index_r;
    shift_byte_nxt = started ? ((cmd == CMD_WRITE) ? data : '0) : shift_byte_r;
    presence_nxt   = presence_r;
    last_read_nxt  = last_read_r;
    phase_nxt      = phase_cur;
    tick_count_nxt = reached ? '0 : tc_inc;
    drive          = 1'b0;
    done           = 1'b0;
    case (phase_cur)
      PH_IDLE: begin
        tick_count_nxt = tc_cur;
      end
      PH_RST_LOW: begin
        drive = 1'b1;
        if (reached) phase_nxt = PH_PRES_WAIT;
      end
      PH_PRES_WAIT: begin
        if (reached) begin
          presence_nxt = !line_in;
          phase_nxt    = PH_RST_REC;
        end
      end
      PH_RST_REC: begin
        if (reached) begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      PH_SLOT_START: begin
        drive = 1'b1;
        if (reached) phase_nxt = PH_SLOT_BODY;
      end
      PH_SLOT_BODY: begin
        // A write holds the bit level for the slot; a read samples on the
        // first released tick and shifts the bit in from the top.
        if (op_nxt == CMD_WRITE) begin
          drive = !shift_byte_nxt[0];
        end else if (tc_cur == '0) begin
          shift_byte_nxt = {line_in, shift_byte_nxt[BYTE_W-1:1]};
        end
        if (reached) begin
          if (op_nxt == CMD_WRITE) shift_byte_nxt = {1'b0, shift_byte_nxt[BYTE_W-1:1]};
          if (bit_index_nxt == LAST_BIT) begin
            if (op_nxt == CMD_READ) last_read_nxt = shift_byte_nxt;
            done      = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            bit_index_nxt = bit_index_nxt + 1'b1;
            phase_nxt     = (recovery_r == '0) ? PH_SLOT_START : PH_SLOT_REC;
          end
        end
      end
      PH_SLOT_REC: begin
        if (reached) phase_nxt = PH_SLOT_START;
      end
      default: begin
        phase_nxt      = PH_IDLE;
        tick_count_nxt = tc_cur;
      end
    endcase
  end

  assign out_tdata_nxt = {3'b000, rejected, last_read_nxt, presence_nxt, done, busy, drive};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      op_r         <= CMD_NONE;
      tick_count_r <= '0;
      bit_index_r  <= '0;
      shift_byte_r <= '0;
      presence_r   <= 1'b0;
      last_read_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r      <= phase_nxt;
        op_r         <= op_nxt;
        tick_count_r <= tick_count_nxt;
        bit_index_r  <= bit_index_nxt;
        shift_byte_r <= shift_byte_nxt;
        presence_r   <= presence_nxt;
        last_read_r  <= last_read_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_tdata_r <= out_tdata_nxt;
  end

  `ASSERT_SAME_CYCLE(a_done_busy, out_tvalid_r && out_tdata_r[2], out_tdata_r[1], "done without busy")
  `ASSERT_SAME_CYCLE(a_drive_busy, out_tvalid_r && out_tdata_r[0], out_tdata_r[1], "drive while idle")
  `ASSERT_SAME_CYCLE(a_idle_count, phase_r == PH_IDLE, tick_count_r == '0, "idle with count")
  `ASSERT_NEXT_CYCLE(a_fire_valid, in_fire, out_tvalid_r, "accepted word gave no result")

endmodule
